// ===== sv/cbsu_pkg.sv =====
// Package for the CB-prefix rotate/shift/bit unit.
// Holds opcode field codes, flag bit positions, cycle counts and the shift function.
// No dependencies.
`default_nettype none

package cbsu_pkg;

    // Opcode bits 7:6: operation group
    localparam logic [1:0] GRP_SHIFT = 2'd0;
    localparam logic [1:0] GRP_BIT   = 2'd1;
    localparam logic [1:0] GRP_RES   = 2'd2;
    localparam logic [1:0] GRP_SET   = 2'd3;

    // Opcode bits 5:3 inside the shift group
    localparam logic [2:0] SH_RLC  = 3'd0;
    localparam logic [2:0] SH_RRC  = 3'd1;
    localparam logic [2:0] SH_RL   = 3'd2;
    localparam logic [2:0] SH_RR   = 3'd3;
    localparam logic [2:0] SH_SLA  = 3'd4;
    localparam logic [2:0] SH_SRA  = 3'd5;
    localparam logic [2:0] SH_SWAP = 3'd6;
    localparam logic [2:0] SH_SRL  = 3'd7;

    // Operand indexes: B,C,D,E,H,L,(HL),A
    localparam logic [2:0] IDX_H   = 3'd4;
    localparam logic [2:0] IDX_L   = 3'd5;
    localparam logic [2:0] IDX_MEM = 3'd6;

    // Flag bit positions: Z N H C
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    localparam logic [4:0]  CYC_REG = 5'd8;
    localparam logic [4:0]  CYC_MEM = 5'd16;
    localparam logic [15:0] PC_STEP = 16'd2;

    typedef struct packed {
        logic [7:0] result;
        logic       carry;
    } shift_res_t;

    // Rotate / shift / swap of one byte; cin is the old carry flag
    function automatic shift_res_t shift_op(input logic [2:0] op, input logic [7:0] v,
                                            input logic cin);
        shift_res_t r;
        r.carry  = 1'b0;
        r.result = v;
        case (op)
            SH_RLC:  begin r.carry = v[7]; r.result = {v[6:0], v[7]}; end
            SH_RRC:  begin r.carry = v[0]; r.result = {v[0], v[7:1]}; end
            SH_RL:   begin r.carry = v[7]; r.result = {v[6:0], cin}; end
            SH_RR:   begin r.carry = v[0]; r.result = {cin, v[7:1]}; end
            SH_SLA:  begin r.carry = v[7]; r.result = {v[6:0], 1'b0}; end
            SH_SRA:  begin r.carry = v[0]; r.result = {v[7], v[7:1]}; end
            SH_SWAP: begin r.carry = 1'b0; r.result = {v[3:0], v[7:4]}; end
            default: begin r.carry = v[0]; r.result = {1'b0, v[7:1]}; end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/cb_prefix_bit_shift_unit_core.sv =====
// CB-prefix rotate/shift/bit execution unit, top level.
// Register file in a synchronous memory, flags and PC in flops.
// Depends on cbsu_pkg.
`default_nettype none

// One CB-prefixed instruction per transfer: the opcode byte plus the byte at HL come in,
// and one result transfer goes out carrying the memory write (for (HL) forms), HL,
// the new flags, the architectural cycle count (8 or 16) and the next PC. With no back
// pressure the unit accepts one instruction every clock cycle. The register-file memory
// is read at the accepting edge into the execute stage; execute loads the output register
// when that register is free or draining, and the result transfers from there. A stalled,
// full output register holds execute and stalls the input in the same cycle. A register
// written by one instruction is forwarded to the instruction right behind it, so
// dependent instructions also run at one per cycle with no back pressure. The register
// file, flags and PC are zero after reset, with no clearing pass: per-entry valid bits
// make unwritten registers read as zero.
module cb_prefix_bit_shift_unit_core
    import cbsu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  cb_opcode,
    input  wire logic [7:0]  memory_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             mem_write_enable,
    output logic [15:0]      mem_address,
    output logic [7:0]       mem_write_data,
    output logic [3:0]       flags_out,
    output logic [4:0]       cycle_count,
    output logic [15:0]      next_pc
);

    // Register file memory and its valid bits
    logic [7:0] rf_mem [0:7];
    logic [7:0] rf_vld_reg;

    // Execute stage
    logic       s1_valid_reg;
    logic [7:0] s1_opcode_reg;
    logic [7:0] s1_mem_byte_reg;
    logic [7:0] rd_data_reg;
    logic       rd_vld_reg;
    logic       fwd_hit_reg;
    logic [7:0] fwd_data_reg;

    // Architectural state outside the memory
    logic [3:0]  flags_reg;
    logic [3:0]  flags_next;
    logic [15:0] pc_reg;
    logic [15:0] pc_next;
    logic [7:0]  h_reg;
    logic [7:0]  l_reg;

    // Output register
    logic        out_valid_reg;
    logic        mem_we_reg;
    logic [15:0] mem_addr_reg;
    logic [7:0]  mem_wdata_reg;
    logic [3:0]  flags_out_reg;
    logic [4:0]  cyc_reg;
    logic [15:0] next_pc_reg;

    logic       in_accept;
    logic       out_free;
    logic       s1_adv;
    logic [1:0] grp;
    logic [2:0] sel;
    logic [2:0] idx;
    logic       is_mem;
    logic [7:0] reg_val;
    logic [7:0] opnd;
    logic [7:0] mask;
    logic [7:0] res;
    logic       writes;
    shift_res_t shift;
    logic       wr_en;
    logic [2:0] wr_addr;
    logic [7:0] wr_data;

    // Handshake: execute moves forward when the output register is free or draining
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    // Decode the staged opcode
    assign grp    = s1_opcode_reg[7:6];
    assign sel    = s1_opcode_reg[5:3];
    assign idx    = s1_opcode_reg[2:0];
    assign is_mem = (idx == IDX_MEM);

    // Pick the operand: forwarded write, memory read, or zero for never-written entries
    assign reg_val = fwd_hit_reg ? fwd_data_reg : (rd_vld_reg ? rd_data_reg : 8'h00);
    assign opnd    = is_mem ? s1_mem_byte_reg : reg_val;
    assign mask    = 8'h01 << sel;
    assign shift   = shift_op(sel, opnd, flags_reg[FLAG_C]);

    // Execute the operation and form the new flags
    always_comb
    begin
        res        = opnd;
        writes     = 1'b1;
        flags_next = flags_reg;
        unique case (grp)
            GRP_SHIFT:
            begin
                res                = shift.result;
                flags_next         = 4'h0;
                flags_next[FLAG_Z] = (shift.result == 8'h00);
                flags_next[FLAG_C] = shift.carry;
            end
            GRP_BIT:
            begin
                writes             = 1'b0;
                flags_next[FLAG_Z] = ((opnd & mask) == 8'h00);
                flags_next[FLAG_N] = 1'b0;
                flags_next[FLAG_H] = 1'b1;
            end
            GRP_RES:
            begin
                res = opnd & ~mask;
            end
            default:
            begin
                res = opnd | mask;
            end
        endcase
    end

    assign wr_en   = s1_adv && writes && !is_mem;
    assign wr_addr = idx;
    assign wr_data = res;
    assign pc_next = pc_reg + PC_STEP;

    // Register file memory: write back on execute, registered read on accept
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rf_mem[wr_addr] <= wr_data;
        end
        if (in_accept)
        begin
            rd_data_reg     <= rf_mem[cb_opcode[2:0]];
            s1_opcode_reg   <= cb_opcode;
            s1_mem_byte_reg <= memory_byte;
            fwd_data_reg    <= wr_data;
        end
    end

    // Capture the read qualifiers and the forward match at accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
                rd_vld_reg   <= rf_vld_reg[cb_opcode[2:0]];
                fwd_hit_reg  <= wr_en && (wr_addr == cb_opcode[2:0]);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Commit flags, PC, valid bits and the HL shadow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_vld_reg <= 8'h00;
            flags_reg  <= 4'h0;
            pc_reg     <= 16'h0000;
            h_reg      <= 8'h00;
            l_reg      <= 8'h00;
        end
        else
        begin
            if (s1_adv)
            begin
                flags_reg <= flags_next;
                pc_reg    <= pc_next;
            end
            if (wr_en)
            begin
                rf_vld_reg[wr_addr] <= 1'b1;
                if (wr_addr == IDX_H)
                begin
                    h_reg <= wr_data;
                end
                if (wr_addr == IDX_L)
                begin
                    l_reg <= wr_data;
                end
            end
        end
    end

    // Output register valid: load on execute, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            mem_we_reg    <= writes && is_mem;
            mem_addr_reg  <= {h_reg, l_reg};
            mem_wdata_reg <= (writes && is_mem) ? res : 8'h00;
            flags_out_reg <= flags_next;
            cyc_reg       <= is_mem ? CYC_MEM : CYC_REG;
            next_pc_reg   <= pc_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign mem_write_enable = mem_we_reg;
    assign mem_address      = mem_addr_reg;
    assign mem_write_data   = mem_wdata_reg;
    assign flags_out        = flags_out_reg;
    assign cycle_count      = cyc_reg;
    assign next_pc          = next_pc_reg;

`ifndef ASSERT_OFF
    // The memory operand slot is never written into the register file
    a_no_mem_slot_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_addr != IDX_MEM))
        else $error("register file write to memory operand slot");

    // PC advances by two for each executed instruction
    a_pc_step: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> (pc_reg == $past(pc_reg) + PC_STEP))
        else $error("PC did not advance by two");

    // A memory write only comes from an (HL) form
    a_mem_write_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && mem_we_reg) |-> (cyc_reg == CYC_MEM))
        else $error("memory write from a register form");

    // Write data is zero without a memory write
    a_wdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !mem_we_reg) |-> (mem_wdata_reg == 8'h00))
        else $error("write data nonzero without memory write");

    // Input stalls only when execute is held by a full output register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without back pressure");
`endif

endmodule

`default_nettype wire
